FILE: rtl/sortable_fifo_queue_assert.svh
// ============================================================================
// Sortable FIFO queue assertion macros
// Shorthand for the clocked, reset-gated properties used by the checker.
// ============================================================================
`ifndef SORTABLE_FIFO_QUEUE_ASSERT_SVH
`define SORTABLE_FIFO_QUEUE_ASSERT_SVH

// same-cycle implication
`define SFQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sfq_pkg.sv
// ============================================================================
// Sortable FIFO queue package
// Operation and status codes shared by the queue and its checker.
// ============================================================================
package sfq_pkg;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_SORT   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

endpackage

FILE: rtl/sortable_fifo_queue.sv
// ============================================================================
// Sortable FIFO queue
// Circular buffer of signed words in one synchronous RAM, with push, pop,
// sorted insert and whole-queue sort.
// ============================================================================
// A word is taken when start is high and busy is low; its result appears for
// one cycle with done high, in the cycle after the queue finishes the word.
// Push, pop and any error are done in the idle state, so one of these can be
// started every cycle. A sorted insert and a sort of n >= 2 entries keep busy
// high while both walk the single-port RAM at one read, then one compare or
// write, per entry, and a sort is a selection sort that swaps through the one
// write port in S_SRT_W1 and S_SRT_W2. The receiver cannot stall the result.
module sortable_fifo_queue #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] popped,
    output logic [1:0]         status,
    output logic [4:0]         count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_SRT_RD,
        S_SRT_CMP,
        S_SRT_W1,
        S_SRT_W2
    } state_t;

    // logical index from head to RAM address, wrapping at DEPTH
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] hd,
                                           input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = (CW+1)'(hd) + (CW+1)'(idx);
        if (s >= (CW+1)'(DEPTH))
            s = s - (CW+1)'(DEPTH);
        return AW'(s);
    endfunction

    state_t               state_reg,  state_next;
    logic [AW-1:0]        head_reg,   head_next;
    logic [CW-1:0]        cnt_reg,    cnt_next;
    logic [CW-1:0]        idx_reg,    idx_next;
    logic [CW-1:0]        base_reg,   base_next;
    logic [CW-1:0]        minpos_reg, minpos_next;
    logic                 found_reg,  found_next;
    logic signed [31:0]   carry_reg,  carry_next;
    logic signed [31:0]   min_reg,    min_next;
    logic signed [31:0]   first_reg,  first_next;
    logic                 done_reg,   done_next;
    logic                 popok_reg,  popok_next;
    sfq_pkg::status_t     status_reg, status_next;

    logic signed [31:0]   mem [DEPTH];
    logic signed [31:0]   rd_q;
    logic                 rd_en;
    logic [CW-1:0]        rd_idx;
    logic                 wr_en;
    logic [CW-1:0]        wr_idx;
    logic signed [31:0]   wr_data;

    logic                 full;
    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        cnt_m2;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_m2 = cnt_reg - CW'(2);

    // reads always trail the writes they depend on
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[slot(head_reg, wr_idx)] <= wr_data;
        if (rd_en)
            rd_q <= mem[slot(head_reg, rd_idx)];
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        base_next   = base_reg;
        minpos_next = minpos_reg;
        found_next  = found_reg;
        carry_next  = carry_reg;
        min_next    = min_reg;
        first_next  = first_reg;
        done_next   = 1'b0;
        popok_next  = 1'b0;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_idx      = idx_reg;
        wr_en       = 1'b0;
        wr_idx      = idx_reg;
        wr_data     = carry_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (sfq_pkg::kind_t'(kind))
                        sfq_pkg::KIND_PUSH:
                        begin
                            done_next = 1'b1;
                            if (full)
                                status_next = sfq_pkg::ST_FULL;
                            else
                            begin
                                status_next = sfq_pkg::ST_OK;
                                wr_en       = 1'b1;
                                wr_idx      = cnt_reg;
                                wr_data     = value;
                                cnt_next    = cnt_reg + CW'(1);
                            end
                        end
                        sfq_pkg::KIND_POP:
                        begin
                            done_next = 1'b1;
                            if (cnt_reg == '0)
                                status_next = sfq_pkg::ST_EMPTY;
                            else
                            begin
                                status_next = sfq_pkg::ST_OK;
                                popok_next  = 1'b1;
                                rd_en       = 1'b1;
                                rd_idx      = '0;
                                head_next   = slot(head_reg, CW'(1));
                                cnt_next    = cnt_m1;
                            end
                        end
                        sfq_pkg::KIND_INSERT:
                        begin
                            if (full)
                            begin
                                done_next   = 1'b1;
                                status_next = sfq_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = '0;
                                found_next = 1'b0;
                                carry_next = value;
                                state_next = S_INS_RD;
                            end
                        end
                        sfq_pkg::KIND_SORT:
                        begin
                            if (cnt_reg < CW'(2))
                            begin
                                done_next   = 1'b1;
                                status_next = sfq_pkg::ST_OK;
                            end
                            else
                            begin
                                base_next  = '0;
                                idx_next   = '0;
                                state_next = S_SRT_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    wr_en       = 1'b1;
                    wr_idx      = cnt_reg;
                    wr_data     = carry_reg;
                    cnt_next    = cnt_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = sfq_pkg::ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                // past the insertion point every entry shifts one place up
                if (found_reg || (rd_q > carry_reg))
                begin
                    wr_en      = 1'b1;
                    carry_next = rd_q;
                    found_next = 1'b1;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_INS_RD;
            end
            S_SRT_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SRT_CMP;
            end
            S_SRT_CMP:
            begin
                if (idx_reg == base_reg)
                begin
                    min_next    = rd_q;
                    first_next  = rd_q;
                    minpos_next = idx_reg;
                end
                else if (rd_q < min_reg)
                begin
                    min_next    = rd_q;
                    minpos_next = idx_reg;
                end
                if (idx_reg == cnt_m1)
                    state_next = S_SRT_W1;
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SRT_RD;
                end
            end
            S_SRT_W1:
            begin
                wr_en      = 1'b1;
                wr_idx     = base_reg;
                wr_data    = min_reg;
                state_next = S_SRT_W2;
            end
            S_SRT_W2:
            begin
                wr_en   = 1'b1;
                wr_idx  = minpos_reg;
                wr_data = first_reg;
                if (base_reg == cnt_m2)
                begin
                    done_next   = 1'b1;
                    status_next = sfq_pkg::ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    base_next  = base_reg + CW'(1);
                    idx_next   = base_reg + CW'(1);
                    state_next = S_SRT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            popok_reg  <= 1'b0;
            status_reg <= sfq_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            popok_reg  <= popok_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        base_reg   <= base_next;
        minpos_reg <= minpos_next;
        found_reg  <= found_next;
        carry_reg  <= carry_next;
        min_reg    <= min_next;
        first_reg  <= first_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign popped = popok_reg ? rd_q : '0;
    assign status = status_reg;
    assign count  = sfq_pkg::COUNT_W'(cnt_reg);

endmodule

FILE: rtl/sfq_checker.sv
// ============================================================================
// Sortable FIFO queue checker
// Port-level properties of the queue, attached to it by bind.
// ============================================================================
`include "sortable_fifo_queue_assert.svh"

module sfq_checker #(
    parameter int DEPTH = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         kind,
    input logic               done,
    input logic signed [31:0] popped,
    input logic [1:0]         status,
    input logic [4:0]         count
);

    `SFQ_ASSERT_NEXT(a_fast_ops, start && !busy && (kind == sfq_pkg::KIND_PUSH || kind == sfq_pkg::KIND_POP), done, "push or pop result missing")
    `SFQ_ASSERT_SAME(a_done_idle, done, !busy, "result while still busy")
    `SFQ_ASSERT_SAME(a_err_zero, done && status != sfq_pkg::ST_OK, popped == 32'sd0, "nonzero word on error")
    `SFQ_ASSERT_SAME(a_empty_cnt, done && status == sfq_pkg::ST_EMPTY, count == 5'd0, "empty error with entries held")
    `SFQ_ASSERT_SAME(a_full_cnt, done && status == sfq_pkg::ST_FULL, count == 5'(DEPTH), "full error below depth")

endmodule

bind sortable_fifo_queue sfq_checker #(.DEPTH(DEPTH)) u_sfq_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Sortable FIFO queue testbench
// Drives push, pop, sorted insert and sort words through the start/busy
// handshake, first from a short directed script and then at random, with the
// queue swinging between empty and full. Each done strobe is checked field by
// field against a typed script row, else a software queue of accepted words.
// ============================================================================
module testbench;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 850;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUIET_FIRST  = 400;
    localparam int QUIET_LAST   = 560;

    typedef struct packed {
        logic signed [31:0] popped;
        sfq_pkg::status_t   status;
        logic [4:0]         count;
    } queue_result_t;

    typedef struct {
        sfq_pkg::kind_t kind;
        logic [31:0]    value;
        bit             typed;
        queue_result_t  result;
    } script_row_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         kind = sfq_pkg::KIND_PUSH;
    logic signed [31:0] value = '0;
    logic               done;
    logic signed [31:0] popped;
    logic [1:0]         status;
    logic [4:0]         count;

    logic signed [31:0] held_words[$];
    queue_result_t      awaited_results[$];
    script_row_t        script[$];
    queue_result_t      expected;
    int                 words_sent = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;
    int                 pick;
    bit                 fill_mode = 1'b1;

    sortable_fifo_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .value(value),
        .done(done),
        .popped(popped),
        .status(status),
        .count(count)
    );

    function automatic queue_result_t apply_word(sfq_pkg::kind_t op, logic signed [31:0] v);
        queue_result_t      r;
        int                 pos;
        int                 j;
        logic signed [31:0] key;
        r.popped = '0;
        r.status = sfq_pkg::ST_OK;
        case (op)
            sfq_pkg::KIND_PUSH, sfq_pkg::KIND_INSERT:
            begin
                if (held_words.size() >= DEPTH)
                    r.status = sfq_pkg::ST_FULL;
                else if (op == sfq_pkg::KIND_PUSH)
                    held_words.push_back(v);
                else
                begin
                    pos = 0;
                    while (pos < held_words.size() && held_words[pos] <= v)
                        pos++;
                    held_words.insert(pos, v);
                end
            end
            sfq_pkg::KIND_POP:
            begin
                if (held_words.size() == 0)
                    r.status = sfq_pkg::ST_EMPTY;
                else
                    r.popped = held_words.pop_front();
            end
            default:
            begin
                for (pos = 1; pos < held_words.size(); pos++)
                begin
                    key = held_words[pos];
                    j = pos;
                    while (j > 0 && held_words[j - 1] > key)
                    begin
                        held_words[j] = held_words[j - 1];
                        j--;
                    end
                    held_words[j] = key;
                end
            end
        endcase
        r.count = 5'(held_words.size());
        return r;
    endfunction

    task automatic add_row(sfq_pkg::kind_t k, logic [31:0] v, bit typed, logic [31:0] p = '0,
                           sfq_pkg::status_t s = sfq_pkg::ST_OK, logic [4:0] c = '0);
        script_row_t row;
        row.kind = k;
        row.value = v;
        row.typed = typed;
        row.result.popped = p;
        row.result.status = s;
        row.result.count = c;
        script.push_back(row);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        add_row(sfq_pkg::KIND_POP,    32'h0000_0000, 1, 32'h0, sfq_pkg::ST_EMPTY, 5'd0);
        add_row(sfq_pkg::KIND_SORT,   32'hFFFF_FFFF, 1, 32'h0, sfq_pkg::ST_OK, 5'd0);
        add_row(sfq_pkg::KIND_PUSH,   32'h7FFF_FFFF, 1, 32'h0, sfq_pkg::ST_OK, 5'd1);
        add_row(sfq_pkg::KIND_SORT,   32'h0000_0000, 1, 32'h0, sfq_pkg::ST_OK, 5'd1);
        add_row(sfq_pkg::KIND_POP,    32'h0000_0000, 1, 32'h7FFF_FFFF, sfq_pkg::ST_OK, 5'd0);
        add_row(sfq_pkg::KIND_INSERT, 32'h8000_0000, 1, 32'h0, sfq_pkg::ST_OK, 5'd1);
        add_row(sfq_pkg::KIND_PUSH,   32'hFFFF_FFFF, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'h0000_0000, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'h0000_0001, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'h0000_0003, 0);
        add_row(sfq_pkg::KIND_INSERT, 32'h0000_0005, 0);
        add_row(sfq_pkg::KIND_INSERT, 32'hFFFF_FFFB, 0);
        add_row(sfq_pkg::KIND_INSERT, 32'h0000_0000, 0);
        add_row(sfq_pkg::KIND_INSERT, 32'h7FFF_FFFF, 0);
        add_row(sfq_pkg::KIND_INSERT, 32'h8000_0000, 0);
        add_row(sfq_pkg::KIND_SORT,   32'h1234_5678, 0);
        add_row(sfq_pkg::KIND_POP,    32'hFFFF_FFFF, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'hAAAA_AAAA, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'h5555_5555, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'hFFFF_0000, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'h0000_FFFF, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'h1234_5678, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'hEDCB_A987, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'h7FFF_FFFE, 0);
        add_row(sfq_pkg::KIND_PUSH,   32'h0000_0042, 1, 32'h0, sfq_pkg::ST_FULL, 5'd16);
        add_row(sfq_pkg::KIND_INSERT, 32'h8000_0000, 1, 32'h0, sfq_pkg::ST_FULL, 5'd16);
        add_row(sfq_pkg::KIND_SORT,   32'h0000_0000, 1, 32'h0, sfq_pkg::ST_OK, 5'd16);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            kind <= sfq_pkg::KIND_PUSH;
            value <= '0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: popped %0d status %0d count %0d",
                           popped, status, count);
                    mismatches++;
                end
                else
                begin
                    expected = awaited_results.pop_front();
                    if (popped !== expected.popped)
                    begin
                        $error("popped: expected %0d, actual %0d", expected.popped, popped);
                        mismatches++;
                    end
                    if (status !== expected.status)
                    begin
                        $error("status: expected %0d, actual %0d", expected.status, status);
                        mismatches++;
                    end
                    if (count !== expected.count)
                    begin
                        $error("count: expected %0d, actual %0d", expected.count, count);
                        mismatches++;
                    end
                end
            end

            if (start && !busy)
            begin
                expected = apply_word(sfq_pkg::kind_t'(kind), value);
                if (words_sent < script.size() && script[words_sent].typed)
                    expected = script[words_sent].result;
                awaited_results.push_back(expected);
                words_sent++;
            end

            if (!(start && busy))
            begin
                if (words_sent >= script.size() + RANDOM_WORDS
                    || ((words_sent < QUIET_FIRST || words_sent >= QUIET_LAST)
                        && $urandom_range(0, 99) < 11))
                    start <= 1'b0;
                else if (words_sent < script.size())
                begin
                    start <= 1'b1;
                    kind <= script[words_sent].kind;
                    value <= script[words_sent].value;
                end
                else
                begin
                    // swing between filling and draining so both ends get hit
                    if (held_words.size() >= DEPTH)
                        fill_mode = 1'b0;
                    else if (held_words.size() == 0)
                        fill_mode = 1'b1;
                    else if ($urandom_range(0, 49) == 0)
                        fill_mode = !fill_mode;
                    pick = $urandom_range(0, 99);
                    start <= 1'b1;
                    if (fill_mode)
                        kind <= pick < 40 ? sfq_pkg::KIND_PUSH
                              : pick < 75 ? sfq_pkg::KIND_INSERT
                              : pick < 90 ? sfq_pkg::KIND_POP : sfq_pkg::KIND_SORT;
                    else
                        kind <= pick < 15 ? sfq_pkg::KIND_PUSH
                              : pick < 25 ? sfq_pkg::KIND_INSERT
                              : pick < 88 ? sfq_pkg::KIND_POP : sfq_pkg::KIND_SORT;
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        value <= $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    else if (pick < 4)
                        value <= 32'($urandom_range(0, 8)) - 32'd4;
                    else
                        value <= $urandom;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sortable_fifo_queue verification failed");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (words_sent < script.size() + RANDOM_WORDS)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("sortable_fifo_queue verification clean");
        else
            $display("sortable_fifo_queue verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/sfq_pkg.sv
rtl/sortable_fifo_queue.sv
rtl/sfq_checker.sv
verif/testbench.sv
